/* rtl/core/lsrg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsrg_pkg
// shared constants and types of the line span rectangle generator
// ----------------------------------------------------------------------------
package lsrg_pkg;

    // default coordinate width; the divider width defaults to one bit more
    localparam int COORD_BITS_DEF = 10;
    localparam int COLOR_BITS     = 16;

    // command codes carried in tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // status of the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage
`default_nettype wire

/* rtl/core/lsrg_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsrg_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lsrg_div #(
    parameter int W = lsrg_pkg::COORD_BITS_DEF + 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [W-1:0]         i_num,
    input  wire logic [W-1:0]         i_den,
    output lsrg_pkg::t_div_status     o_stat,
    output logic      [W-1:0]         o_quot
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quot;
    logic [W-1:0]     r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0]       w_trial;
    logic [W:0]       w_diff;
    logic             w_ge;
    logic [W-1:0]     n_rem;

    // shift in the next dividend bit, subtract when it fits
    assign w_trial = {r_rem, r_quot[W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign n_rem   = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= CNT_W'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule
`default_nettype wire

/* rtl/core/line_span_rectangle_generator_unit.sv */
`default_nettype none
// a start gives no result; a step on an active line runs the serial divider, waits in
//   ST_FIN until the output register is free, then puts its rectangle there
// the input stays closed for the whole step: divider run, quotient seen in ST_FIN, then the
//   output register loaded and the unit back in ST_IDLE, which re-opens the input
// reset: synchronous, active low; clears the line state to zero and leaves the unit idle
// ----------------------------------------------------------------------------
// line_span_rectangle_generator_unit
// splits a line into a run of filled rectangles, one per step transaction
// ----------------------------------------------------------------------------
module line_span_rectangle_generator_unit #(
    parameter int COORD_BITS = lsrg_pkg::COORD_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // input stream
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // x_start, y_start, x_end, y_end, color (lowest bit first)
    input  wire logic [((4*COORD_BITS+lsrg_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // cmd
    input  wire logic [0:0] s_axis_tuser,
    // output stream
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // rect_x, rect_y, rect_w, rect_h, rect_color (lowest bit first), zero padded
    output logic [((4*COORD_BITS+2+lsrg_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    // last
    output logic      m_axis_tlast
);

    localparam int CB    = COORD_BITS;
    localparam int SW    = COORD_BITS + 1;   // size width, holds 1 .. 2^CB
    localparam int CLR_W = lsrg_pkg::COLOR_BITS;
    localparam int OUT_W = ((4*COORD_BITS+2+lsrg_pkg::COLOR_BITS+7)/8)*8;

    // state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       r_state;

    // line state
    logic [CB-1:0]    r_cur_x;
    logic [CB-1:0]    r_cur_y;
    logic [CB-1:0]    r_stop_x;
    logic [CB-1:0]    r_stop_y;
    logic [CLR_W-1:0] r_color;
    logic             r_active;

    // per-step context kept while the divider runs
    logic             r_tall;
    logic             r_down;
    logic [SW-1:0]    r_dx;

    // output register
    logic             r_out_valid;
    logic [CB-1:0]    r_rect_x;
    logic [CB-1:0]    r_rect_y;
    logic [SW-1:0]    r_rect_w;
    logic [SW-1:0]    r_rect_h;
    logic [CLR_W-1:0] r_rect_color;
    logic             r_rect_last;

    // unpacked input fields
    logic             w_cmd;
    logic [CB-1:0]    w_x_start;
    logic [CB-1:0]    w_y_start;
    logic [CB-1:0]    w_x_end;
    logic [CB-1:0]    w_y_end;
    logic [CLR_W-1:0] w_color;

    logic             w_in_acc;
    logic             w_start_acc;
    logic             w_step_acc;
    logic             w_swap;

    logic [SW-1:0]    w_dx;
    logic             w_down;
    logic [SW-1:0]    w_mag;
    logic             w_tall;
    logic [SW-1:0]    w_num;
    logic [SW-1:0]    w_den;

    lsrg_pkg::t_div_status w_div_stat;
    logic [SW-1:0]    w_quot;

    logic [SW-1:0]    w_w;
    logic [SW-1:0]    w_h;
    logic             w_last;
    logic             w_fin_go;
    logic [CB-1:0]    w_top;
    logic [CB-1:0]    w_next_y;

    assign w_cmd     = s_axis_tuser[0];
    assign w_x_start = s_axis_tdata[CB-1:0];
    assign w_y_start = s_axis_tdata[2*CB-1:CB];
    assign w_x_end   = s_axis_tdata[3*CB-1:2*CB];
    assign w_y_end   = s_axis_tdata[4*CB-1:3*CB];
    assign w_color   = s_axis_tdata[4*CB+CLR_W-1:4*CB];

    // one transaction at a time; the output register lets the next one in
    // while a finished rectangle still waits downstream
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_start_acc   = w_in_acc && (w_cmd == lsrg_pkg::CMD_START);
    // a step while idle is taken and dropped
    assign w_step_acc    = w_in_acc && (w_cmd == lsrg_pkg::CMD_STEP) && r_active;

    // endpoints are ordered so that x rises
    assign w_swap = w_x_start > w_x_end;

    // remaining span; an active line always has cur_x <= stop_x
    assign w_dx   = {1'b0, r_stop_x} - {1'b0, r_cur_x} + SW'(1);
    assign w_down = r_stop_y >= r_cur_y;
    assign w_mag  = w_down ? ({1'b0, r_stop_y} - {1'b0, r_cur_y} + SW'(1))
                           : ({1'b0, r_cur_y} - {1'b0, r_stop_y} + SW'(1));
    assign w_tall = w_mag > w_dx;
    // the larger extent is divided by the smaller
    assign w_num  = w_tall ? w_mag : w_dx;
    assign w_den  = w_tall ? w_dx : w_mag;

    lsrg_div #(
        .W (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_step_acc),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    // rectangle from the quotient; the other side is one pixel
    assign w_w    = r_tall ? SW'(1) : w_quot;
    assign w_h    = r_tall ? w_quot : SW'(1);
    // cur_x + w passes stop_x exactly when w covers the whole span
    assign w_last = w_w >= r_dx;
    // a rising line ends one row above cur_y, wrapping at row 0
    assign w_top    = r_down ? r_cur_y : (r_cur_y - w_h[CB-1:0]);
    assign w_next_y = r_down ? (r_cur_y + w_h[CB-1:0]) : w_top;
    assign w_fin_go = (r_state == ST_FIN) && (!r_out_valid || m_axis_tready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_step_acc) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_fin_go) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_stop_x <= '0;
            r_stop_y <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else if (w_start_acc) begin
            // a new line drops any running one
            r_cur_x  <= w_swap ? w_x_end   : w_x_start;
            r_cur_y  <= w_swap ? w_y_end   : w_y_start;
            r_stop_x <= w_swap ? w_x_start : w_x_end;
            r_stop_y <= w_swap ? w_y_start : w_y_end;
            r_color  <= w_color;
            r_active <= 1'b1;
        end else if (w_fin_go) begin
            r_cur_x  <= r_cur_x + w_w[CB-1:0];
            r_cur_y  <= w_next_y;
            r_active <= !w_last;
        end
    end

    // step context
    always_ff @(posedge i_clk) begin
        if (w_step_acc) begin
            r_tall <= w_tall;
            r_down <= w_down;
            r_dx   <= w_dx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_rect_x     <= r_cur_x;
            r_rect_y     <= w_top;
            r_rect_w     <= w_w;
            r_rect_h     <= w_h;
            r_rect_color <= r_color;
            r_rect_last  <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_rect_color, r_rect_h, r_rect_w, r_rect_y, r_rect_x});
    assign m_axis_tlast  = r_rect_last;

    // divider only reports back while a step is waiting for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ST_DIV))
        else $error("divider finished outside of a step");

    // a step in progress always belongs to an active line
    a_step_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_FIN) |-> r_active)
        else $error("step in progress without an active line");

    // the closing rectangle leaves the unit idle
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && w_last) |=> !r_active)
        else $error("line still active after its last rectangle");

    // every rectangle is one pixel thin on at least one side and never empty
    a_rect_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_rect_w == SW'(1) || r_rect_h == SW'(1))
                         && r_rect_w != '0 && r_rect_h != '0))
        else $error("malformed rectangle");

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for line_span_rectangle_generator_unit: directed lines,
// then random lines under three sender/receiver idling mixes and a long
// output hold-off, every rectangle checked against a behavioral line splitter
// ----------------------------------------------------------------------------
module testbench;

    localparam int CB   = lsrg_pkg::COORD_BITS_DEF;
    localparam int CLR  = lsrg_pkg::COLOR_BITS;
    localparam int S_W  = ((4*CB + CLR + 7)/8)*8;
    localparam int M_W  = ((4*CB + 2 + CLR + 7)/8)*8;
    localparam int CMAX = (1 << CB) - 1;

    // how long the receiver holds off during the pressure phase
    localparam int HOLD_CYCLES = 300;
    // cycles to let pass after the last rectangle, well above the step latency
    localparam int DRAIN_CYCLES = 3*CB;

    // one input transaction, fields named as in the line command
    typedef struct packed {
        logic          cmd;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
        logic [15:0]   color;
    } t_line_item;

    // one output transaction
    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CB:0]   w;
        logic [CB:0]   h;
        logic [15:0]   color;
        logic          last;
    } t_rect;

    // directed table row; when typed is set, exp is the known rectangle
    typedef struct packed {
        t_line_item item;
        bit         typed;
        t_rect      exp;
    } t_dir_row;

    // line walker state, mirrors what the unit keeps between steps
    typedef struct {
        logic [CB-1:0] cur_x;
        logic [CB-1:0] cur_y;
        logic [CB-1:0] stop_x;
        logic [CB-1:0] stop_y;
        logic [15:0]   color;
        bit            active;
    } t_line_state;

    logic           i_clk         = 1'b0;
    logic           i_rst_n       = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [S_W-1:0] s_axis_tdata  = '0;
    logic [0:0]     s_axis_tuser  = lsrg_pkg::CMD_STEP;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [M_W-1:0] m_axis_tdata;
    logic           m_axis_tlast;

    t_rect       pending_rects [$];
    t_line_state line_st;
    int          err_cnt       = 0;
    int          items_done    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req      = 1'b0;
    int          hold_cnt      = 0;
    t_dir_row    dir_tab [25];

    line_span_rectangle_generator_unit #(
        .COORD_BITS(CB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // x_start, y_start, x_end, y_end, color (lowest bit first)
        .s_axis_tdata  (s_axis_tdata),
        // cmd
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // rect_x, rect_y, rect_w, rect_h, rect_color, zero padding (lowest bit first)
        .m_axis_tdata  (m_axis_tdata),
        // last
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the unit hangs
    initial begin
        #2_000_000;
        $display("line_span_rectangle_generator_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // line splitter: the behavior the unit must reproduce
    // ------------------------------------------------------------------------

    // latch endpoints so that x rises, plus the color
    function automatic void start_line(inout t_line_state st, input t_line_item it);
        if (it.xs > it.xe) begin
            st.cur_x  = it.xe;
            st.cur_y  = it.ye;
            st.stop_x = it.xs;
            st.stop_y = it.ys;
        end else begin
            st.cur_x  = it.xs;
            st.cur_y  = it.ys;
            st.stop_x = it.xe;
            st.stop_y = it.ye;
        end
        st.color  = it.color;
        st.active = 1'b1;
    endfunction

    // next rectangle of the running line; returns 0 when idle
    function automatic bit step_line(inout t_line_state st, output t_rect r);
        int          dx;
        int          diff;
        int          mag;
        int          w;
        int          h;
        int          top;
        int          ny;
        int unsigned nx;
        bit          down;
        r = '0;
        if (!st.active)
            return 1'b0;
        dx   = int'(st.stop_x) - int'(st.cur_x) + 1;
        diff = int'(st.stop_y) - int'(st.cur_y);
        down = diff >= 0;
        mag  = (down ? diff : -diff) + 1;
        if (dx < 1)
            dx = 1;
        // the longer side is split by the shorter one, truncating
        if (mag > dx) begin
            h = mag / dx;
            w = 1;
        end else begin
            w = dx / mag;
            h = 1;
        end
        // a rising line puts the rectangle just above the current row
        if (down) begin
            top = int'(st.cur_y);
            ny  = int'(st.cur_y) + h;
        end else begin
            top = int'(st.cur_y) - h;
            ny  = top;
        end
        nx = st.cur_x + w;
        r.x     = st.cur_x;
        r.y     = top[CB-1:0];
        r.w     = w[CB:0];
        r.h     = h[CB:0];
        r.color = st.color;
        r.last  = nx > st.stop_x;
        st.cur_x = nx[CB-1:0];
        st.cur_y = ny[CB-1:0];
        if (r.last)
            st.active = 1'b0;
        return 1'b1;
    endfunction

    // number of rectangles left in a line, walked on a copy of the state
    function automatic int count_rects(t_line_state st);
        t_rect r;
        int    n;
        n = 0;
        while (n < 4*(CMAX + 1) && step_line(st, r))
            n++;
        return n;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : (v > CMAX) ? CMAX : v;
    endfunction

    // endpoints favor the borders of the coordinate range
    function automatic int edge_coord();
        case ($urandom_range(3))
            0:       return 0;
            1:       return CMAX;
            default: return $urandom_range(CMAX);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_cnt++;
    endtask

    // every output transaction is matched against the oldest pending rectangle
    always @(posedge i_clk) begin : rect_check
        t_rect got;
        t_rect want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x     = m_axis_tdata[CB-1:0];
            got.y     = m_axis_tdata[2*CB-1:CB];
            got.w     = m_axis_tdata[3*CB:2*CB];
            got.h     = m_axis_tdata[4*CB+1:3*CB+1];
            got.color = m_axis_tdata[4*CB+2+CLR-1:4*CB+2];
            got.last  = m_axis_tlast;
            if (m_axis_tdata[M_W-1:4*CB+2+CLR] !== '0)
                report_mismatch("tdata padding", m_axis_tdata[M_W-1:4*CB+2+CLR], 0);
            if (pending_rects.size() == 0) begin
                report_mismatch("unexpected rectangle", got, 0);
            end else begin
                want = pending_rects.pop_front();
                if (got.x !== want.x)         report_mismatch("rect_x", got.x, want.x);
                if (got.y !== want.y)         report_mismatch("rect_y", got.y, want.y);
                if (got.w !== want.w)         report_mismatch("rect_w", got.w, want.w);
                if (got.h !== want.h)         report_mismatch("rect_h", got.h, want.h);
                if (got.color !== want.color) report_mismatch("rect_color", got.color, want.color);
                if (got.last !== want.last)   report_mismatch("last", got.last, want.last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random backpressure, plus one long hold-off counted here
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            hold_cnt      <= hold_cnt + 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // offer one transaction, wait for it to be taken, then predict its result;
    // a typed rectangle stands in for the predicted one where the table gives it
    task automatic send_item(input t_line_item it, input bit typed, input t_rect typed_rect);
        t_rect r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.color, it.ye, it.xe, it.ys, it.xs};
        s_axis_tuser  <= it.cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_done++;
        if (it.cmd == lsrg_pkg::CMD_START) begin
            start_line(line_st, it);
        end else if (line_st.active) begin
            void'(step_line(line_st, r));
            pending_rects.push_back(typed ? typed_rect : r);
        end
    endtask

    // stop offering and wait until every pending rectangle has come out
    task automatic drain_rects();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_rects.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // a start followed by steps: mostly the full line, sometimes cut short
    // (next start drops it) or overrun (steps while idle)
    task automatic run_random_line();
        t_line_item it;
        t_rect      none;
        int         kind;
        int         n;
        int         steps;
        int         bx;
        int         by;
        none = '0;
        kind = $urandom_range(99);
        it.color = 16'($urandom_range(16'hFFFF));
        // noise: any command with any content
        if (kind < 8) begin
            it.cmd = 1'($urandom_range(1));
            it.xs  = CB'($urandom_range(CMAX));
            it.ys  = CB'($urandom_range(CMAX));
            it.xe  = CB'($urandom_range(CMAX));
            it.ye  = CB'($urandom_range(CMAX));
            send_item(it, 1'b0, none);
            return;
        end
        it.cmd = lsrg_pkg::CMD_START;
        if (kind < 75) begin
            // short line around a point, often on a border
            bx    = edge_coord();
            by    = edge_coord();
            it.xs = CB'(clamp_coord(bx + $urandom_range(80) - 40));
            it.ys = CB'(clamp_coord(by + $urandom_range(80) - 40));
            it.xe = CB'(clamp_coord(bx + $urandom_range(80) - 40));
            it.ye = CB'(clamp_coord(by + $urandom_range(80) - 40));
        end else begin
            it.xs = CB'($urandom_range(CMAX));
            it.ys = CB'($urandom_range(CMAX));
            it.xe = CB'($urandom_range(CMAX));
            it.ye = CB'($urandom_range(CMAX));
        end
        send_item(it, 1'b0, none);
        n     = count_rects(line_st);
        steps = (n > 40) ? $urandom_range(40, 1) : n;
        kind  = $urandom_range(99);
        if (kind < 12)
            steps = $urandom_range(steps, 1);
        else if (kind < 20)
            steps = steps + $urandom_range(2, 1);
        it.cmd = lsrg_pkg::CMD_STEP;
        repeat (steps) begin
            it.xs = CB'($urandom_range(CMAX));
            it.ye = CB'($urandom_range(CMAX));
            send_item(it, 1'b0, none);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        line_st = '{default: '0};
        // directed lines: empty, full width, full height, upward wrap past row 0,
        // swapped endpoints, restart while running, far corner, row overflow
        dir_tab = '{
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b0, '0},
            '{'{lsrg_pkg::CMD_START, 10'd0, 10'd0, 10'd0, 10'd0, 16'hFFFF}, 1'b0, '0},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b1,
              '{10'd0, 10'd0, 11'd1, 11'd1, 16'hFFFF, 1'b1}},
            '{'{lsrg_pkg::CMD_STEP, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF},
              1'b0, '0},
            '{'{lsrg_pkg::CMD_START, 10'd0, 10'd0, 10'd1023, 10'd0, 16'h0000}, 1'b0, '0},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b1,
              '{10'd0, 10'd0, 11'd1024, 11'd1, 16'h0000, 1'b1}},
            '{'{lsrg_pkg::CMD_START, 10'd0, 10'd0, 10'd0, 10'd1023, 16'hA5A5}, 1'b0, '0},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b1,
              '{10'd0, 10'd0, 11'd1, 11'd1024, 16'hA5A5, 1'b1}},
            '{'{lsrg_pkg::CMD_START, 10'd0, 10'd1023, 10'd0, 10'd0, 16'h5A5A}, 1'b0, '0},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b1,
              '{10'd0, 10'd1023, 11'd1, 11'd1024, 16'h5A5A, 1'b1}},
            '{'{lsrg_pkg::CMD_START, 10'd1023, 10'd1023, 10'd0, 10'd0, 16'h0001},
              1'b0, '0},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b1,
              '{10'd0, 10'd0, 11'd1, 11'd1, 16'h0001, 1'b0}},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b0, '0},
            '{'{lsrg_pkg::CMD_START, 10'd1023, 10'd0, 10'd0, 10'd1023, 16'h8000},
              1'b0, '0},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b1,
              '{10'd0, 10'd1022, 11'd1, 11'd1, 16'h8000, 1'b0}},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b0, '0},
            '{'{lsrg_pkg::CMD_START, 10'd100, 10'd200, 10'd50, 10'd60, 16'h1234},
              1'b0, '0},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b1,
              '{10'd50, 10'd60, 11'd1, 11'd2, 16'h1234, 1'b0}},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b0, '0},
            '{'{lsrg_pkg::CMD_START, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF},
              1'b0, '0},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b1,
              '{10'd1023, 10'd1023, 11'd1, 11'd1, 16'hFFFF, 1'b1}},
            '{'{lsrg_pkg::CMD_START, 10'd0, 10'd1023, 10'd0, 10'd1023, 16'h0000},
              1'b0, '0},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b1,
              '{10'd0, 10'd1023, 11'd1, 11'd1, 16'h0000, 1'b1}},
            '{'{lsrg_pkg::CMD_START, 10'd300, 10'd5, 10'd700, 10'd2, 16'h07E0}, 1'b0, '0},
            '{'{lsrg_pkg::CMD_STEP, 10'd0, 10'd0, 10'd0, 10'd0, 16'h0000}, 1'b0, '0}
        };

        // reset, held at the start and never again
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 1: sender idles lightly, receiver heavily
        send_idle_pct = 10;
        recv_idle_pct = 72;
        foreach (dir_tab[i])
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].exp);
        while (items_done < 250)
            run_random_line();
        drain_rects();

        // phase 2: the other way round
        send_idle_pct = 72;
        recv_idle_pct = 10;
        while (items_done < 480)
            run_random_line();
        drain_rects();

        // phase 3: no idling; first a long receiver hold-off while a long
        // diagonal keeps being stepped, so the unit fills and stalls its input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        begin : pressure
            t_line_item it;
            t_rect      none;
            none  = '0;
            it    = '0;
            it.cmd   = lsrg_pkg::CMD_START;
            it.xe    = CB'(CMAX);
            it.ye    = CB'(CMAX);
            it.color = 16'hC3C3;
            send_item(it, 1'b0, none);
            it.cmd = lsrg_pkg::CMD_STEP;
            repeat (30)
                send_item(it, 1'b0, none);
        end
        // sender pause until every rectangle so far has come out
        drain_rects();
        while (items_done < 700)
            run_random_line();
        drain_rects();

        if (err_cnt == 0)
            $display("line_span_rectangle_generator_unit verification clean");
        else
            $display("line_span_rectangle_generator_unit verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lsrg_pkg.sv
rtl/core/lsrg_div.sv
rtl/core/line_span_rectangle_generator_unit.sv
test/testbench.sv
